### src/note_arpeggiator_core_macros.svh
// Assertion macros shared by the arpeggiator RTL.
`ifndef NOTE_ARPEGGIATOR_CORE_MACROS_SVH
`define NOTE_ARPEGGIATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/narp_pkg.sv
// Types and constants of the note arpeggiator.
package narp_pkg;

    localparam int FREQ_W     = 16;
    localparam int OUT_W      = 19;
    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int OCT_W      = 3;
    localparam int RND_W      = 16;
    localparam int STEP_W     = 7;
    // Divisor and step arithmetic width: the total of notes times octaves is at most 64 with 16 notes.
    localparam int DIV_W      = 8;
    // Dividend width of the shared divider, wide enough for the random value.
    localparam int DVD_W      = 16;
    localparam int DIV_CNT_W  = 4;
    localparam int SHIFT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OCT_W-1:0]    OCT_MIN        = 3'd1;
    localparam logic [OCT_W-1:0]    OCT_MAX        = 3'd4;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd100;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ARP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd2;

    typedef enum logic [1:0] {
        MODE_UP       = 2'd0,
        MODE_DOWN     = 2'd1,
        MODE_PINGPONG = 2'd2,
        MODE_RANDOM   = 2'd3
    } t_arp_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_STEP,
        ST_DIV,
        ST_READ,
        ST_OUT
    } t_state;

endpackage

### src/note_arpeggiator_core.sv
// Note arpeggiator: packs active sensor frequencies and emits one arpeggiated tone per scan.
//
// Usage: sensors of a scan arrive one word each on the input channel
// (i_in_valid / o_in_stall). Active frequencies go into a note store of
// MAX_NOTES entries; later active sensors are dropped once it is full.
// A word without last_sensor is taken while the sequencer is idle. A word with
// last_sensor starts the sequencer and yields one word on the output channel
// (o_out_valid / i_out_stall) through PREP, STEP, DIV, READ and OUT; the
// shared restoring divider makes one pass for step / count, and one more for
// random mod total in random mode on an advance. An empty scan goes from PREP
// to OUT and yields 0; a lone note over one octave skips STEP and DIV.
// The input channel stalls while the sequencer runs. A waiting result sits in
// the output register; the final step of the next scan holds until it has been
// taken, and sensors of that scan are still taken meanwhile.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set the mode,
// octave count and step period; unknown indexes are ignored.
// Synchronous active-low reset clears the note count, step, direction, time
// of last advance and registers (mode up, one octave, period 100 ms).
`include "note_arpeggiator_core_macros.svh"

module note_arpeggiator_core #(
    parameter int MAX_NOTES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_sensor_active,
    input  logic [narp_pkg::FREQ_W-1:0]        i_sensor_freq,
    input  logic                               i_last_sensor,
    input  logic [narp_pkg::TIME_W-1:0]        i_now_ms,
    input  logic [narp_pkg::RND_W-1:0]         i_random_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [narp_pkg::OUT_W-1:0]         o_out_freq,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [narp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [narp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import narp_pkg::*;

    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CW = $clog2(MAX_NOTES + 1);

    // Configuration registers.
    t_arp_mode             r_arp_mode;
    logic [OCT_W-1:0]      r_octave_count;
    logic [PERIOD_W-1:0]   r_step_period;

    // Sequencer and architectural state.
    t_state                r_state, n_state;
    logic [CW-1:0]         r_count;
    logic [STEP_W-1:0]     r_step_index;
    logic                  r_going_down;
    logic [TIME_W-1:0]     r_last_adv;

    // Scan snapshot and working registers.
    logic [CW-1:0]         r_n;
    logic [TIME_W-1:0]     r_now;
    logic [RND_W-1:0]      r_rnd;
    logic [OCT_W-1:0]      r_oct;
    logic [DIV_W-1:0]      r_total;
    logic                  r_adv;
    logic                  r_zero;

    // Shared divider.
    logic [DVD_W-1:0]      r_dvd;
    logic [DIV_W-1:0]      r_dvs;
    logic [DIV_W-1:0]      r_rem;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic                  r_div_rand;

    // Note store and its read port.
    logic [FREQ_W-1:0]     r_mem [MAX_NOTES];
    logic [AW-1:0]         r_rd_addr;
    logic [FREQ_W-1:0]     r_rdata;
    logic [SHIFT_W-1:0]    r_shift;

    // Output register.
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_freq;

    logic                  w_in_accept;
    logic                  w_out_free;
    logic                  w_store;
    logic [CW-1:0]         w_count_inc;
    logic [OCT_W-1:0]      w_oct;
    logic [DIV_W-1:0]      w_total;
    logic [TIME_W-1:0]     w_elapsed;
    logic [DIV_W-1:0]      w_s;
    logic [DIV_W-1:0]      w_s_inc;
    logic [DIV_W-1:0]      w_t_dec;
    logic [DIV_W-1:0]      w_stepped;
    logic                  w_flip;
    logic [DIV_W-1:0]      w_pick;
    logic [DIV_W-1:0]      w_clamped;
    logic [DIV_W:0]        w_rem_sh;
    logic                  w_qbit;
    logic [DIV_W-1:0]      w_rem_new;
    logic [DVD_W-1:0]      w_quot;

    // Handshake-side control.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        w_in_accept = i_in_valid && (r_state == ST_IDLE);
        w_out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_freq  = r_out_freq;

    // Note store fill.
    assign w_store     = w_in_accept && i_sensor_active && (r_count < CW'(MAX_NOTES));
    assign w_count_inc = w_store ? CW'(r_count + CW'(1)) : r_count;

    // Octave clamp, total positions and elapsed-time test.
    always_comb begin
        if (r_octave_count < OCT_MIN) begin
            w_oct = OCT_MIN;
        end else if (r_octave_count > OCT_MAX) begin
            w_oct = OCT_MAX;
        end else begin
            w_oct = r_octave_count;
        end
    end
    assign w_total   = DIV_W'(DIV_W'(r_n) * DIV_W'(w_oct));
    assign w_elapsed = r_now - r_last_adv;

    // Mode step over the stored step index.
    assign w_s     = {1'b0, r_step_index};
    assign w_s_inc = w_s + DIV_W'(1);
    assign w_t_dec = r_total - DIV_W'(1);

    always_comb begin
        w_flip    = 1'b0;
        w_stepped = w_s;
        unique case (r_arp_mode)
            MODE_UP: begin
                w_stepped = (w_s_inc >= r_total) ? '0 : w_s_inc;
            end
            MODE_DOWN: begin
                w_stepped = (w_s == '0) ? w_t_dec : (w_s - DIV_W'(1));
            end
            MODE_PINGPONG: begin
                if (r_going_down) begin
                    w_flip    = (w_s <= DIV_W'(1));
                    w_stepped = w_flip ? '0 : (w_s - DIV_W'(1));
                end else begin
                    w_flip    = (w_s_inc >= w_t_dec);
                    w_stepped = w_flip ? w_t_dec : w_s_inc;
                end
            end
            MODE_RANDOM: begin
                w_stepped = w_s;
            end
            default: begin
                w_stepped = w_s;
            end
        endcase
        w_pick    = r_adv ? w_stepped : w_s;
        w_clamped = (w_pick >= r_total) ? w_t_dec : w_pick;
    end

    // One restoring division step.
    always_comb begin
        w_rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        w_qbit    = (w_rem_sh >= {1'b0, r_dvs});
        w_rem_new = w_qbit ? DIV_W'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[DIV_W-1:0];
        w_quot    = {r_dvd[DVD_W-2:0], w_qbit};
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept && i_last_sensor) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                if (r_n == '0) begin
                    n_state = ST_OUT;
                end else if ((r_n == CW'(1)) && (w_oct == OCT_MIN)) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if ((r_div_cnt == '0) && !r_div_rand) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_arp_mode     <= MODE_UP;
            r_octave_count <= OCT_MIN;
            r_step_period  <= PERIOD_RESET;
            r_count        <= '0;
            r_step_index   <= '0;
            r_going_down   <= 1'b0;
            r_last_adv     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration writes.
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_ARP_MODE) begin
                    r_arp_mode <= t_arp_mode'(i_cfg_data[1:0]);
                end else if (i_cfg_index == CFG_OCTAVES) begin
                    r_octave_count <= i_cfg_data[OCT_W-1:0];
                end else if (i_cfg_index == CFG_PERIOD) begin
                    r_step_period <= i_cfg_data[PERIOD_W-1:0];
                end
            end

            // Note count, cleared at the end of each scan.
            if (w_in_accept) begin
                r_count <= i_last_sensor ? '0 : w_count_inc;
            end

            // Step update and the time of the last advance.
            if (r_state == ST_STEP) begin
                if (r_adv) begin
                    r_last_adv <= r_now;
                end
                if (!(r_adv && (r_arp_mode == MODE_RANDOM))) begin
                    r_step_index <= w_clamped[STEP_W-1:0];
                    if (r_adv && (r_arp_mode == MODE_PINGPONG) && w_flip) begin
                        r_going_down <= !r_going_down;
                    end
                end
            end
            if ((r_state == ST_DIV) && (r_div_cnt == '0) && r_div_rand) begin
                r_step_index <= w_rem_new[STEP_W-1:0];
            end

            // Output valid.
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept && i_last_sensor) begin
            r_n   <= w_count_inc;
            r_now <= i_now_ms;
            r_rnd <= i_random_value;
        end

        if (r_state == ST_PREP) begin
            r_oct     <= w_oct;
            r_total   <= w_total;
            r_adv     <= (w_elapsed >= TIME_W'(r_step_period));
            r_zero    <= (r_n == '0);
            r_rd_addr <= '0;
            r_shift   <= '0;
        end

        // Start a division: random mod total on a random advance, else step by count.
        if (r_state == ST_STEP) begin
            r_rem     <= '0;
            r_div_cnt <= '1;
            if (r_adv && (r_arp_mode == MODE_RANDOM)) begin
                r_dvd      <= r_rnd;
                r_dvs      <= r_total;
                r_div_rand <= 1'b1;
            end else begin
                r_dvd      <= DVD_W'(w_clamped);
                r_dvs      <= DIV_W'(r_n);
                r_div_rand <= 1'b0;
            end
        end

        // Iterate the divider; after the random pass, divide the new step by the count.
        if (r_state == ST_DIV) begin
            if (r_div_cnt != '0) begin
                r_rem     <= w_rem_new;
                r_dvd     <= w_quot;
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end else if (r_div_rand) begin
                r_rem      <= '0;
                r_dvd      <= DVD_W'(w_rem_new);
                r_dvs      <= DIV_W'(r_n);
                r_div_cnt  <= '1;
                r_div_rand <= 1'b0;
            end else begin
                r_rd_addr <= w_rem_new[AW-1:0];
                r_shift   <= w_quot[SHIFT_W-1:0];
            end
        end

        // Final note, shifted up by the octave.
        if ((r_state == ST_OUT) && w_out_free) begin
            r_out_freq <= r_zero ? '0 : OUT_W'({{(OUT_W-FREQ_W){1'b0}}, r_rdata} << r_shift);
        end
    end

    // Note store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[AW-1:0]] <= i_sensor_freq;
        end
        r_rdata <= r_mem[r_rd_addr];
    end

    // Checks.
    `NAC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(MAX_NOTES), "note count beyond store size")
    `NAC_ASSERT_NEXT(a_out_from_seq, !r_out_valid && (r_state != ST_OUT), !r_out_valid, "result without sequencer")
    `NAC_ASSERT_NOW(a_addr_in_scan, (r_state == ST_READ) && !r_zero, CW'(r_rd_addr) < r_n, "note read beyond scan")
    `NAC_ASSERT_NOW(a_shift_bound, (r_state == ST_READ) && !r_zero, {1'b0, r_shift} < r_oct, "octave shift out of range")

endmodule

### sim/tb.sv
// Self-checking testbench for the note arpeggiator core: directed table, then randomized scans.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import narp_pkg::*;

    localparam int MAX_NOTES     = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_WORDS   = 88;
    localparam int RAND_PHASES   = 8;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } t_row_kind;

    // One line of the directed table: a sensor word (repeated) or a register write.
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  active;
        logic [FREQ_W-1:0]     freq;
        logic                  last;
        logic [TIME_W-1:0]     now;
        logic [RND_W-1:0]      rnd;
        logic [4:0]            reps;
        logic                  typed;
        logic [OUT_W-1:0]      tone;
    } t_row;

    // DUT-facing signals; the inputs are known from time zero.
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic                  i_sensor_active = 1'b0;
    logic [FREQ_W-1:0]     i_sensor_freq   = '0;
    logic                  i_last_sensor   = 1'b0;
    logic [TIME_W-1:0]     i_now_ms        = '0;
    logic [RND_W-1:0]      i_random_value  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [OUT_W-1:0]      o_out_freq;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    // Shadow copy of the arpeggiator registers and scan state.
    t_arp_mode         mode_reg   = MODE_UP;
    logic [OCT_W-1:0]  oct_reg    = OCT_MIN;
    logic [PERIOD_W-1:0] period_reg = PERIOD_RESET;
    logic [FREQ_W-1:0] note_mem [MAX_NOTES];
    int                note_cnt   = 0;
    int                step_pos   = 0;
    bit                going_down = 1'b0;
    logic [TIME_W-1:0] last_adv   = '0;

    // Tones still owed by the block, oldest first.
    logic [OUT_W-1:0] tone_expect_q [$];
    logic [OUT_W-1:0] tone_want;

    int  errors        = 0;
    int  tones_checked = 0;
    int  words_taken   = 0;
    int  reg_writes    = 0;
    int  advances      = 0;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    int  hold_left     = 0;
    // The stimulus bumps the request count; the receiver starts a hold-off on each change.
    int  hold_req      = 0;
    int  hold_seen     = 0;

    note_arpeggiator_core #(
        .MAX_NOTES (MAX_NOTES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sensor_active (i_sensor_active),
        .i_sensor_freq   (i_sensor_freq),
        .i_last_sensor   (i_last_sensor),
        .i_now_ms        (i_now_ms),
        .i_random_value  (i_random_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_freq      (o_out_freq),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Apply one accepted sensor word to the shadow state and work out the tone, if any.
    function automatic void arp_predict(input logic act, input logic [FREQ_W-1:0] f,
                                        input logic last, input logic [TIME_W-1:0] now,
                                        input logic [RND_W-1:0] rnd,
                                        output bit emits, output logic [OUT_W-1:0] tone);
        int n;
        int oct;
        int total;
        int stp;
        logic [TIME_W-1:0] elapsed;
        emits = 1'b0;
        tone  = '0;
        if (act && note_cnt < MAX_NOTES) begin
            note_mem[note_cnt] = f;
            note_cnt++;
        end
        if (!last) begin
            return;
        end
        emits = 1'b1;
        n = note_cnt;
        note_cnt = 0;
        oct = int'(oct_reg);
        if (oct < int'(OCT_MIN)) oct = int'(OCT_MIN);
        if (oct > int'(OCT_MAX)) oct = int'(OCT_MAX);
        // Silence with no note; a single note over one octave plays as is.
        if (n == 0) begin
            return;
        end
        if (n == 1 && oct == 1) begin
            tone = OUT_W'(note_mem[0]);
            return;
        end
        total   = n * oct;
        stp     = step_pos;
        elapsed = now - last_adv;
        if (elapsed >= TIME_W'(period_reg)) begin
            last_adv = now;
            advances++;
            case (mode_reg)
                MODE_UP: begin
                    stp++;
                    if (stp >= total) stp = 0;
                end
                MODE_DOWN: begin
                    stp--;
                    if (stp < 0) stp = total - 1;
                end
                MODE_PINGPONG: begin
                    if (going_down) begin
                        stp--;
                        if (stp <= 0) begin
                            stp = 0;
                            going_down = 1'b0;
                        end
                    end else begin
                        stp++;
                        if (stp >= total - 1) begin
                            stp = total - 1;
                            going_down = 1'b1;
                        end
                    end
                end
                default: begin
                    stp = int'(rnd) % total;
                end
            endcase
        end
        // A step left over from a larger pattern is pulled back into range.
        if (stp >= total) stp = total - 1;
        if (stp < 0) stp = 0;
        step_pos = stp;
        tone = OUT_W'(note_mem[stp % n]) << (stp / n);
    endfunction

    function automatic t_row word_row(input logic act, input logic [FREQ_W-1:0] f,
                                      input logic last, input logic [TIME_W-1:0] now,
                                      input logic [RND_W-1:0] rnd, input int reps,
                                      input logic typed, input logic [OUT_W-1:0] tone);
        t_row r;
        r          = '0;
        r.kind     = ROW_WORD;
        r.active   = act;
        r.freq     = f;
        r.last     = last;
        r.now      = now;
        r.rnd      = rnd;
        r.reps     = 5'(reps);
        r.typed    = typed;
        r.tone     = tone;
        return r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r          = '0;
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    // Offer one sensor word, with optional idle cycles first, and wait for it to be taken.
    task automatic send_word(input logic act, input logic [FREQ_W-1:0] f, input logic last,
                             input logic [TIME_W-1:0] now, input logic [RND_W-1:0] rnd,
                             input logic typed, input logic [OUT_W-1:0] typed_tone);
        bit emits;
        logic [OUT_W-1:0] tone;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sensor_active <= act;
        i_sensor_freq   <= f;
        i_last_sensor   <= last;
        i_now_ms        <= now;
        i_random_value  <= rnd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_taken++;
        arp_predict(act, f, last, now, rnd, emits, tone);
        if (emits) begin
            tone_expect_q.push_back(typed ? typed_tone : tone);
        end
    endtask

    // Write one register and mirror it in the shadow copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reg_writes++;
        case (idx)
            CFG_ARP_MODE: mode_reg   = t_arp_mode'(data[1:0]);
            CFG_OCTAVES:  oct_reg    = data[OCT_W-1:0];
            CFG_PERIOD:   period_reg = data[PERIOD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering words, wait for every owed tone, then let the sequencer go quiet.
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tone_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compare every accepted tone with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tone_expect_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: tone %0d arrived with none expected", o_out_freq);
                end
            end else begin
                tone_want = tone_expect_q.pop_front();
                tones_checked++;
                if (o_out_freq !== tone_want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: out_freq expected %0d, got %0d",
                                 tone_want, o_out_freq);
                    end
                end
            end
        end
    end

    // Hard stop if the run hangs.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: errors");
        $finish;
    end

    initial begin : stimulus
        t_row plan [$];
        t_row row;
        t_arp_mode mode_plan [RAND_PHASES];
        int oct_plan [RAND_PHASES];
        int per_plan [RAND_PHASES];
        int idx;
        int k;
        int p;
        int words;
        int nwords;
        logic [CFG_DATA_W-1:0] cfg_word;
        logic [TIME_W-1:0] clock_ms;
        logic is_last;

        for (k = 0; k < MAX_NOTES; k++) begin
            note_mem[k] = '0;
        end

        // Directed part: empty scan, lone notes, a full store, every mode and register extreme.
        plan.push_back(word_row(1'b0, 16'h1234, 1'b1, 32'd0, 16'd0, 1, 1'b1, 19'd0));
        plan.push_back(word_row(1'b1, 16'hFFFF, 1'b1, 32'd0, 16'd0, 1, 1'b1, 19'h0FFFF));
        plan.push_back(word_row(1'b1, 16'd1000, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 16, 1'b0, '0));
        // The store is full here, so the last sensor's own note is dropped.
        plan.push_back(word_row(1'b1, 16'd5555, 1'b1, 32'd100, 16'd0, 1, 1'b0, '0));
        plan.push_back(reg_row(CFG_OCTAVES, 16'd4));
        plan.push_back(reg_row(CFG_ARP_MODE, 16'hFFFD));
        plan.push_back(reg_row(CFG_PERIOD, 16'd0));
        plan.push_back(word_row(1'b1, 16'd440, 1'b0, 32'd0, 16'd0, 1, 1'b0, '0));
        plan.push_back(word_row(1'b1, 16'd880, 1'b1, 32'd0, 16'd0, 1, 1'b0, '0));
        // One note over four octaves: in down mode the step wraps from zero to the top.
        plan.push_back(word_row(1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 16'd0, 1, 1'b0, '0));
        plan.push_back(reg_row(CFG_ARP_MODE, MODE_PINGPONG));
        plan.push_back(word_row(1'b1, 16'd123, 1'b1, 32'd7, 16'd0, 3, 1'b0, '0));
        plan.push_back(reg_row(CFG_ARP_MODE, MODE_RANDOM));
        plan.push_back(word_row(1'b1, 16'hFFFF, 1'b1, 32'd9, 16'hFFFF, 1, 1'b0, '0));
        // Octave count zero behaves as one.
        plan.push_back(reg_row(CFG_OCTAVES, 16'd0));
        plan.push_back(word_row(1'b1, 16'h8001, 1'b1, 32'd9, 16'd0, 1, 1'b1, 19'h08001));
        plan.push_back(reg_row(CFG_OCTAVES, 16'd7));
        plan.push_back(reg_row(CFG_SPARE, 16'hFFFF));
        plan.push_back(reg_row(CFG_PERIOD, 16'hFFFF));
        plan.push_back(word_row(1'b0, 16'hFFFF, 1'b0, 32'd0, 16'd0, 1, 1'b0, '0));
        plan.push_back(word_row(1'b1, 16'd77, 1'b1, 32'd5, 16'd0, 1, 1'b0, '0));

        mode_plan = '{MODE_UP, MODE_PINGPONG, MODE_RANDOM, MODE_DOWN,
                      MODE_PINGPONG, MODE_RANDOM, MODE_UP, MODE_DOWN};
        oct_plan  = '{1, 4, 2, 7, 0, 3, 4, 5};
        per_plan  = '{0, 1, 100, 65535, 3, 7, 0, 30};
        clock_ms  = 32'd1000;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with no idling on either side.
        for (idx = 0; idx < plan.size(); idx++) begin
            row = plan[idx];
            if (row.kind == ROW_REG) begin
                drain_and_settle();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                for (k = 0; k < int'(row.reps); k++) begin
                    send_word(row.active, row.freq + FREQ_W'(k * 37), row.last, row.now,
                              row.rnd, row.typed, row.tone);
                end
            end
        end
        drain_and_settle();

        // Random scans, one register setting and one idling pattern per phase.
        for (p = 0; p < RAND_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 67; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 67; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            cfg_word = CFG_DATA_W'($urandom());
            cfg_word[1:0] = mode_plan[p];
            write_reg(CFG_ARP_MODE, cfg_word);
            cfg_word = CFG_DATA_W'($urandom());
            cfg_word[OCT_W-1:0] = OCT_W'(oct_plan[p]);
            write_reg(CFG_OCTAVES, cfg_word);
            write_reg(CFG_PERIOD, CFG_DATA_W'(per_plan[p]));
            if (p == 2) write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
            // Run the clock across its wrap while the period is at its largest.
            if (p == 3) clock_ms = 32'hFFFE_0000;
            // Hold the receiver off so the block fills and stalls its input.
            if (p == 4) hold_req++;

            words = 0;
            while (words < PHASE_WORDS) begin
                nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20)
                                                      : $urandom_range(1, 5);
                if ($urandom_range(0, 19) == 0) begin
                    clock_ms = $urandom();
                end else begin
                    clock_ms += $urandom_range(0, 2 * per_plan[p] + 2);
                end
                for (k = 0; k < nwords; k++) begin
                    is_last = (k == nwords - 1);
                    send_word($urandom_range(0, 3) != 0, FREQ_W'($urandom()), is_last,
                              is_last ? clock_ms : TIME_W'($urandom()),
                              RND_W'($urandom()), 1'b0, '0);
                end
                words += nwords;
            end
            drain_and_settle();
        end

        $display("summary: %0d sensor words taken, %0d tones checked, %0d step advances,",
                 words_taken, tones_checked, advances);
        $display("summary: %0d register writes over all modes and octave settings, %0d errors",
                 reg_writes, errors);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
